// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the port state tracker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");

// implication in the next cycle
`define ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

// File: src/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// types, codes and constants of the spanning-tree port state tracker
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int PORT_SLOTS_DEF = 32;
    localparam int CFG_W          = 36;

    localparam logic [1:0] ST_DISC  = 2'd0;
    localparam logic [1:0] ST_LEARN = 2'd1;
    localparam logic [1:0] ST_FWD   = 2'd2;

    localparam logic CMD_BPDU  = 1'b0;
    localparam logic CMD_TIMER = 1'b1;

    localparam logic REG_MAX_AGE   = 1'b0;
    localparam logic REG_FWD_DELAY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [15:0]      DEF_PRIO        = 16'd32768;
    localparam logic [31:0]      DEF_COST        = 32'd20000;
    localparam logic [7:0]       TC_FLAG         = 8'h01;
    localparam logic [7:0]       LEN_FLAGS       = 8'd22;
    localparam logic [7:0]       LEN_PRIO        = 8'd24;
    localparam logic [7:0]       LEN_COST        = 8'd34;
    localparam logic [CFG_W-1:0] MAX_AGE_RESET   = 36'd20000000000;
    localparam logic [CFG_W-1:0] FWD_DELAY_RESET = 36'd15000000000;

    typedef struct packed {
        logic [31:0] port_id;
        logic [1:0]  state;
        logic [15:0] prio;
        logic [31:0] cost;
        logic [63:0] last_bpdu;
        logic [63:0] learning_since;
    } entry_t;

    typedef struct packed {
        logic [31:0] port_id;
        logic [1:0]  state;
        logic [15:0] prio;
        logic [31:0] cost;
        logic [63:0] last_bpdu;
        logic        status;
    } res_t;

    typedef struct packed {
        logic   en;
        logic   set_valid;
        entry_t entry;
    } tbl_wr_t;

    function automatic res_t entry_to_res(entry_t e);
        res_t r;
        r.port_id   = e.port_id;
        r.state     = e.state;
        r.prio      = e.prio;
        r.cost      = e.cost;
        r.last_bpdu = e.last_bpdu;
        r.status    = STATUS_OK;
        return r;
    endfunction

endpackage

// File: src/stp_slot_table.sv
// ----------------------------------------------------------------------------
// stp_slot_table
// port slot memory with registered read, valid bits and free slot search
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_slot_table #(
    parameter int PORT_SLOTS = stp_pkg::PORT_SLOTS_DEF,
    parameter int IDX_W      = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output stp_pkg::entry_t       rd_data,
    input  logic [IDX_W-1:0]      wr_addr,
    input  stp_pkg::tbl_wr_t      wr,
    output logic [PORT_SLOTS-1:0] valid_vec,
    output logic                  free_found,
    output logic [IDX_W-1:0]      free_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PORT_SLOTS - 1);

    stp_pkg::entry_t       mem [PORT_SLOTS];
    stp_pkg::entry_t       rd_data_reg;
    logic [PORT_SLOTS-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en && wr.set_valid) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign valid_vec = valid_reg;

    `ASSERT_IMPLY(a_no_rw_clash, aclk, aresetn, wr.en && rd_en, wr_addr != rd_addr)
    `ASSERT_IMPLY(a_wr_in_range, aclk, aresetn, wr.en, wr_addr <= LAST_IDX)
    `ASSERT_IMPLY(a_rd_in_range, aclk, aresetn, rd_en, rd_addr <= LAST_IDX)

endmodule

// File: src/stp_port_state_tracker.sv
// ----------------------------------------------------------------------------
// stp_port_state_tracker
// spanning-tree port state tracker over a table of port slots
// ----------------------------------------------------------------------------
// usage:
//   input channel s_*: one item per transfer, cmd 0 is a received BPDU,
//   cmd 1 a timer scan. result channel m_*: one transfer per port entry
//   write or table-full report, m_last marks the final result of an item.
//   config port cfg_* writes max age (index 0) and forward delay (index 1);
//   the user writes them only when idle; the block does not enforce it.
//   one item at a time; every slot step is one memory read and evaluation
//   per cycle while the receiver does not stall. results leave through an
//   output register held behind a one-entry pending stage, so the first
//   result of an item shows one emit after it is formed, the last one after
//   the walk ends. a stalled receiver holds the walk at the next result.
//   reset clears all slot valid bits and loads the default timer values;
//   the slot memory itself needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_port_state_tracker #(
    parameter int PORT_SLOTS = stp_pkg::PORT_SLOTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [stp_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [31:0]               s_port_id,
    input  logic [63:0]               s_now_time,
    input  logic [63:0]               s_event_time,
    input  logic [7:0]                s_bpdu_length,
    input  logic [7:0]                s_flag_byte,
    input  logic [15:0]               s_priority_word,
    input  logic [31:0]               s_cost_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [31:0]               m_out_port_id,
    output logic [1:0]                m_out_state,
    output logic [15:0]               m_out_priority,
    output logic [31:0]               m_out_cost,
    output logic [63:0]               m_out_last_bpdu,
    output logic                      m_status,
    output logic                      m_last
);

    localparam int               IDX_W    = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PORT_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_ALLOC,
        S_NEXT,
        S_TC,
        S_FEV,
        S_FEV2,
        S_TIMER,
        S_FLUSH
    } fsm_t;

    fsm_t                      state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          hit_reg, hit_next;
    logic                      tc_reg, tc_next;
    logic [31:0]               pid_reg, pid_next;
    logic [63:0]               now_reg, now_next;
    logic [63:0]               evt_reg, evt_next;
    logic [15:0]               prio_reg, prio_next;
    logic [31:0]               cost_reg, cost_next;
    stp_pkg::entry_t           ent_reg, ent_next;
    logic [stp_pkg::CFG_W-1:0] max_age_reg, max_age_next;
    logic [stp_pkg::CFG_W-1:0] fwd_reg, fwd_next;
    stp_pkg::res_t             pend_reg, pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    stp_pkg::res_t             out_reg, out_next;
    logic                      out_last_reg, out_last_next;
    logic                      m_valid_reg, m_valid_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    stp_pkg::entry_t       rd_data;
    logic [IDX_W-1:0]      wr_addr;
    stp_pkg::tbl_wr_t      wr;
    logic [PORT_SLOTS-1:0] valid_vec;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;

    logic            emit_req;
    stp_pkg::res_t   emit_res;
    logic            flush_req;
    logic            can_emit;
    logic            out_free;
    logic            accept;
    logic [63:0]     since_age;
    logic            age_hit;
    logic            fwd_hit;
    logic            match;
    logic            chg;
    stp_pkg::entry_t upd;
    stp_pkg::res_t   full_res;

    stp_slot_table #(
        .PORT_SLOTS(PORT_SLOTS),
        .IDX_W     (IDX_W)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_addr   (wr_addr),
        .wr        (wr),
        .valid_vec (valid_vec),
        .free_found(free_found),
        .free_idx  (free_idx)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;

    // timer tests on the slot just read
    assign since_age = (rd_data.last_bpdu != 64'd0 && now_reg > rd_data.last_bpdu)
                       ? now_reg - rd_data.last_bpdu : 64'd0;
    assign age_hit   = (rd_data.last_bpdu != 64'd0) &&
                       (since_age >= {28'd0, max_age_reg});
    assign fwd_hit   = (rd_data.state == stp_pkg::ST_LEARN) &&
                       (rd_data.learning_since != 64'd0) &&
                       ((now_reg - rd_data.learning_since) >= {28'd0, fwd_reg});
    assign match     = valid_vec[idx_reg] && (rd_data.port_id == pid_reg);

    always_comb begin
        full_res           = '0;
        full_res.port_id   = pid_reg;
        full_res.status    = stp_pkg::STATUS_FULL;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        tc_next      = tc_reg;
        pid_next     = pid_reg;
        now_next     = now_reg;
        evt_next     = evt_reg;
        prio_next    = prio_reg;
        cost_next    = cost_reg;
        ent_next     = ent_reg;
        max_age_next = max_age_reg;
        fwd_next     = fwd_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_addr      = idx_reg;
        wr           = '0;
        emit_req     = 1'b0;
        emit_res     = '0;
        flush_req    = 1'b0;
        chg          = 1'b0;
        upd          = rd_data;

        if (cfg_wr_en) begin
            case (cfg_index)
                stp_pkg::REG_MAX_AGE:   max_age_next = cfg_data;
                stp_pkg::REG_FWD_DELAY: fwd_next     = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    rd_addr  = '0;
                    if (s_cmd == stp_pkg::CMD_TIMER) begin
                        now_next = s_now_time;
                        if (s_now_time != 64'd0) begin
                            rd_en      = 1'b1;
                            state_next = S_TIMER;
                        end
                    end else if (s_port_id != 32'd0) begin
                        pid_next  = s_port_id;
                        now_next  = (s_now_time != 64'd0) ? s_now_time : s_event_time;
                        evt_next  = s_event_time;
                        tc_next   = (s_bpdu_length >= stp_pkg::LEN_FLAGS) &&
                                    ((s_flag_byte & stp_pkg::TC_FLAG) != 8'd0);
                        prio_next = (s_bpdu_length >= stp_pkg::LEN_PRIO)
                                    ? s_priority_word : stp_pkg::DEF_PRIO;
                        cost_next = (s_bpdu_length >= stp_pkg::LEN_COST)
                                    ? s_cost_word : stp_pkg::DEF_COST;
                        rd_en      = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end

            S_LOOK: begin
                if (match) begin
                    upd.last_bpdu = evt_reg;
                    upd.prio      = prio_reg;
                    upd.cost      = cost_reg;
                    wr.en         = 1'b1;
                    wr.entry      = upd;
                    hit_next      = idx_reg;
                    state_next    = S_NEXT;
                end else if (idx_reg == LAST_IDX) begin
                    if (free_found) begin
                        state_next = S_ALLOC;
                    end else if (can_emit) begin
                        emit_req   = 1'b1;
                        emit_res   = full_res;
                        state_next = S_FLUSH;
                    end
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_ALLOC: begin
                wr.en                    = 1'b1;
                wr.set_valid             = 1'b1;
                wr.entry.port_id         = pid_reg;
                wr.entry.state           = stp_pkg::ST_DISC;
                wr.entry.prio            = prio_reg;
                wr.entry.cost            = cost_reg;
                wr.entry.last_bpdu       = evt_reg;
                wr.entry.learning_since  = 64'd0;
                wr_addr                  = free_idx;
                hit_next                 = free_idx;
                state_next               = S_NEXT;
            end

            S_NEXT: begin
                rd_en = 1'b1;
                if (tc_reg) begin
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = S_TC;
                end else begin
                    rd_addr    = hit_reg;
                    state_next = S_FEV;
                end
            end

            S_TC: begin
                chg                = valid_vec[idx_reg] && (rd_data.state == stp_pkg::ST_FWD);
                upd.state          = stp_pkg::ST_LEARN;
                upd.learning_since = now_reg;
                if (!chg || can_emit) begin
                    if (chg) begin
                        wr.en    = 1'b1;
                        wr.entry = upd;
                        emit_req = 1'b1;
                        emit_res = stp_pkg::entry_to_res(upd);
                    end
                    if (idx_reg == LAST_IDX) begin
                        tc_next    = 1'b0;
                        state_next = S_NEXT;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_FEV: begin
                wr_addr = hit_reg;
                if (can_emit) begin
                    emit_req = 1'b1;
                    if (rd_data.state == stp_pkg::ST_DISC) begin
                        upd.state          = stp_pkg::ST_LEARN;
                        upd.learning_since = now_reg;
                        wr.en              = 1'b1;
                        wr.entry           = upd;
                        ent_next           = upd;
                        emit_res           = stp_pkg::entry_to_res(upd);
                        state_next         = S_FEV2;
                    end else begin
                        emit_res   = stp_pkg::entry_to_res(rd_data);
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FEV2: begin
                if (can_emit) begin
                    emit_req   = 1'b1;
                    emit_res   = stp_pkg::entry_to_res(ent_reg);
                    state_next = S_FLUSH;
                end
            end

            S_TIMER: begin
                chg = valid_vec[idx_reg] &&
                      ((age_hit && rd_data.state != stp_pkg::ST_DISC) || (!age_hit && fwd_hit));
                if (age_hit) begin
                    upd.state          = stp_pkg::ST_DISC;
                    upd.learning_since = 64'd0;
                end else begin
                    upd.state          = stp_pkg::ST_FWD;
                end
                if (!chg || can_emit) begin
                    if (chg) begin
                        wr.en    = 1'b1;
                        wr.entry = upd;
                        emit_req = 1'b1;
                        emit_res = stp_pkg::entry_to_res(upd);
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FLUSH;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    flush_req  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // pending stage and output register
    always_comb begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (emit_req) begin
            if (pend_valid_reg) begin
                out_next      = pend_reg;
                out_last_next = 1'b0;
                m_valid_next  = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end else if (flush_req) begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            m_valid_next    = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            max_age_reg    <= stp_pkg::MAX_AGE_RESET;
            fwd_reg        <= stp_pkg::FWD_DELAY_RESET;
            tc_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            max_age_reg    <= max_age_next;
            fwd_reg        <= fwd_next;
            tc_reg         <= tc_next;
        end
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        pid_reg      <= pid_next;
        now_reg      <= now_next;
        evt_reg      <= evt_next;
        prio_reg     <= prio_next;
        cost_reg     <= cost_next;
        ent_reg      <= ent_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_port_id   = out_reg.port_id;
    assign m_out_state     = out_reg.state;
    assign m_out_priority  = out_reg.prio;
    assign m_out_cost      = out_reg.cost;
    assign m_out_last_bpdu = out_reg.last_bpdu;
    assign m_status        = out_reg.status;
    assign m_last          = out_last_reg;

    `ASSERT_IMPLY(a_ready_no_pend, aclk, aresetn, s_ready, !pend_valid_reg)
    `ASSERT_IMPLY(a_full_is_last, aclk, aresetn, m_valid && m_status, m_last)
    `ASSERT_NEXT(a_emit_loads_out, aclk, aresetn, emit_req && pend_valid_reg, m_valid)

endmodule

// File: bench/tb_stp_port_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stp_port_state_tracker
// self-checking bench for the spanning-tree port state tracker
// ----------------------------------------------------------------------------
// Drives BPDU and timer-scan items through the valid/ready input channel.
// A behavioral copy of the port table works out the entry writes that each
// accepted item causes. Every result transfer is compared field by field
// against the oldest pending entry write. A short directed table comes
// first, then random traffic under several max-age and forward-delay
// settings. Both channels idle at random, and at one point the receiver
// holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_stp_port_state_tracker;

    localparam int  SLOTS     = stp_pkg::PORT_SLOTS_DEF;
    localparam int  SETTLE    = 2 * SLOTS + 40;
    localparam int  LIMIT     = 600000;
    localparam longint unsigned FWD_DEF = 64'd15000000000;

    typedef struct {
        logic        cmd;
        logic [31:0] port_id;
        logic [63:0] now_t;
        logic [63:0] evt_t;
        logic [7:0]  len;
        logic [7:0]  flags;
        logic [15:0] prio;
        logic [31:0] cost;
    } bpdu_item_t;

    typedef struct {
        logic [31:0] port_id;
        logic [1:0]  state;
        logic [15:0] prio;
        logic [31:0] cost;
        logic [63:0] last_bpdu;
        logic        status;
        logic        last;
    } entry_wr_t;

    typedef struct {
        bpdu_item_t item;
        bit         typed;
        bit         has_res;
        entry_wr_t  final_wr;
    } dir_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic                      cfg_index;
    logic [stp_pkg::CFG_W-1:0] cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_cmd;
    logic [31:0]               s_port_id;
    logic [63:0]               s_now_time;
    logic [63:0]               s_event_time;
    logic [7:0]                s_bpdu_length;
    logic [7:0]                s_flag_byte;
    logic [15:0]               s_priority_word;
    logic [31:0]               s_cost_word;
    logic                      m_valid;
    logic                      m_ready;
    logic [31:0]               m_out_port_id;
    logic [1:0]                m_out_state;
    logic [15:0]               m_out_priority;
    logic [31:0]               m_out_cost;
    logic [63:0]               m_out_last_bpdu;
    logic                      m_status;
    logic                      m_last;

    // port table copy
    bit          tbl_valid [SLOTS];
    logic [31:0] tbl_pid   [SLOTS];
    logic [1:0]  tbl_state [SLOTS];
    logic [15:0] tbl_prio  [SLOTS];
    logic [31:0] tbl_cost  [SLOTS];
    logic [63:0] tbl_last  [SLOTS];
    logic [63:0] tbl_since [SLOTS];
    logic [stp_pkg::CFG_W-1:0] max_age;
    logic [stp_pkg::CFG_W-1:0] fwd_delay;

    entry_wr_t   pending_wr[$];
    entry_wr_t   step_wr[$];
    int          s_idle_pct;
    int          r_idle_pct;
    int          hold_cycles;
    int          cycles;
    int          mismatches;
    int          items_sent;
    int          results_seen;
    int          full_seen;
    logic [63:0] t_now;

    stp_port_state_tracker u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_port_id       (s_port_id),
        .s_now_time      (s_now_time),
        .s_event_time    (s_event_time),
        .s_bpdu_length   (s_bpdu_length),
        .s_flag_byte     (s_flag_byte),
        .s_priority_word (s_priority_word),
        .s_cost_word     (s_cost_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_port_id   (m_out_port_id),
        .m_out_state     (m_out_state),
        .m_out_priority  (m_out_priority),
        .m_out_cost      (m_out_cost),
        .m_out_last_bpdu (m_out_last_bpdu),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic entry_wr_t slot_wr(int s);
        entry_wr_t w;
        w.port_id   = tbl_pid[s];
        w.state     = tbl_state[s];
        w.prio      = tbl_prio[s];
        w.cost      = tbl_cost[s];
        w.last_bpdu = tbl_last[s];
        w.status    = stp_pkg::STATUS_OK;
        w.last      = 1'b0;
        return w;
    endfunction

    task automatic move_port(int s, logic [1:0] st, logic [63:0] now);
        if (tbl_state[s] != st) begin
            tbl_state[s] = st;
            if (st == stp_pkg::ST_LEARN) tbl_since[s] = now;
            if (st == stp_pkg::ST_DISC) tbl_since[s] = '0;
            step_wr.push_back(slot_wr(s));
        end
    endtask

    // fills step_wr with the entry writes of one item and updates the table
    task automatic track_ports(bpdu_item_t it);
        logic [63:0] now;
        logic [63:0] age;
        logic [7:0]  flags;
        logic [15:0] prio;
        logic [31:0] cost;
        entry_wr_t   w;
        int          hit;
        int          free_s;
        step_wr.delete();
        now = it.now_t;
        if (it.cmd == stp_pkg::CMD_TIMER) begin
            if (now == 0) return;
            for (int i = 0; i < SLOTS; i++) begin
                if (!tbl_valid[i]) continue;
                age = (tbl_last[i] > 0 && now > tbl_last[i]) ? now - tbl_last[i] : 64'd0;
                if (tbl_last[i] > 0 && age >= {28'd0, max_age}) begin
                    move_port(i, stp_pkg::ST_DISC, now);
                    continue;
                end
                if (tbl_state[i] == stp_pkg::ST_LEARN && tbl_since[i] > 0 &&
                    now - tbl_since[i] >= {28'd0, fwd_delay})
                    move_port(i, stp_pkg::ST_FWD, now);
            end
            if (step_wr.size() > 0) step_wr[step_wr.size() - 1].last = 1'b1;
            return;
        end
        if (it.port_id == 0) return;
        if (now == 0) now = it.evt_t;
        hit = -1;
        free_s = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_pid[i] == it.port_id) begin
                hit = i;
                break;
            end
            if (!tbl_valid[i] && free_s < 0) free_s = i;
        end
        if (hit < 0) begin
            if (free_s < 0) begin
                w = '{it.port_id, stp_pkg::ST_DISC, 16'd0, 32'd0, 64'd0,
                      stp_pkg::STATUS_FULL, 1'b1};
                step_wr.push_back(w);
                return;
            end
            hit = free_s;
            tbl_valid[hit] = 1'b1;
            tbl_pid[hit]   = it.port_id;
            tbl_state[hit] = stp_pkg::ST_DISC;
            tbl_since[hit] = '0;
        end
        flags = '0;
        prio  = stp_pkg::DEF_PRIO;
        cost  = stp_pkg::DEF_COST;
        if (it.len >= stp_pkg::LEN_FLAGS) begin
            flags = it.flags;
            if (it.len >= stp_pkg::LEN_PRIO) prio = it.prio;
            if (it.len >= stp_pkg::LEN_COST) cost = it.cost;
        end
        tbl_last[hit] = it.evt_t;
        tbl_prio[hit] = prio;
        tbl_cost[hit] = cost;
        if ((flags & stp_pkg::TC_FLAG) != 0) begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i] && tbl_state[i] == stp_pkg::ST_FWD)
                    move_port(i, stp_pkg::ST_LEARN, now);
        end
        if (tbl_state[hit] == stp_pkg::ST_DISC) move_port(hit, stp_pkg::ST_LEARN, now);
        w = slot_wr(hit);
        w.last = 1'b1;
        step_wr.push_back(w);
    endtask

    // offer one item and wait for its transfer; called in the step of a rising edge
    task automatic offer_item(bpdu_item_t it);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= it.cmd;
        s_port_id       <= it.port_id;
        s_now_time      <= it.now_t;
        s_event_time    <= it.evt_t;
        s_bpdu_length   <= it.len;
        s_flag_byte     <= it.flags;
        s_priority_word <= it.prio;
        s_cost_word     <= it.cost;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_tracked(bpdu_item_t it);
        offer_item(it);
        track_ports(it);
        foreach (step_wr[i]) pending_wr.push_back(step_wr[i]);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_wr.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_timers(logic [stp_pkg::CFG_W-1:0] age_v,
                                logic [stp_pkg::CFG_W-1:0] fwd_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= stp_pkg::REG_MAX_AGE;
        cfg_data  <= age_v;
        @(posedge aclk);
        cfg_index <= stp_pkg::REG_FWD_DELAY;
        cfg_data  <= fwd_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_age   = age_v;
        fwd_delay = fwd_v;
    endtask

    function automatic bpdu_item_t mk(logic cmd, logic [31:0] pid, logic [63:0] now,
                                      logic [63:0] evt, logic [7:0] len, logic [7:0] flg,
                                      logic [15:0] pr, logic [31:0] cst);
        bpdu_item_t it;
        it = '{cmd, pid, now, evt, len, flg, pr, cst};
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bpdu_item_t random_item();
        bpdu_item_t it;
        int         pick;
        t_now = t_now + $urandom_range(0, 1200);
        pick  = $urandom_range(99);
        it    = mk(stp_pkg::CMD_BPDU, $urandom_range(1, 40), t_now,
                   t_now - $urandom_range(0, 50),
                   8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                : $urandom_range(34, 60)),
                   8'($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                : ($urandom_range(0, 255) & 8'hFE)),
                   16'($urandom), $urandom);
        if (pick < 35) begin
            it.cmd = stp_pkg::CMD_TIMER;
        end else if (pick < 50) begin
            case ($urandom_range(0, 4))
                0: it.port_id = $urandom;
                1: it.now_t = rand64();
                2: it.evt_t = rand64();
                3: it.now_t = '0;
                default: it.port_id = '0;
            endcase
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) send_tracked(random_item());
        drain();
    endtask

    // result check
    always @(posedge aclk) begin
        entry_wr_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_status == stp_pkg::STATUS_FULL) full_seen++;
            if (pending_wr.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: port %h state %0d", m_out_port_id,
                             m_out_state);
            end else begin
                e = pending_wr.pop_front();
                if (m_out_port_id !== e.port_id || m_out_state !== e.state ||
                    m_out_priority !== e.prio || m_out_cost !== e.cost ||
                    m_out_last_bpdu !== e.last_bpdu || m_status !== e.status ||
                    m_last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%h/%h/%h/%0d/%0d got %h/%0d/%h/%h/%h/%0d/%0d",
                                 e.port_id, e.state, e.prio, e.cost, e.last_bpdu, e.status,
                                 e.last, m_out_port_id, m_out_state, m_out_priority,
                                 m_out_cost, m_out_last_bpdu, m_status, m_last);
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[stp_port_state_tracker] ERROR");
            $finish;
        end
    end

    initial begin
        dir_row_t  rows [$];
        dir_row_t  r;
        entry_wr_t none;
        aclk = 0; aresetn = 0; cfg_wr_en = 0; cfg_index = stp_pkg::REG_MAX_AGE;
        cfg_data = '0;
        s_valid = 0; s_cmd = stp_pkg::CMD_BPDU; s_port_id = '0; s_now_time = '0;
        s_event_time = '0;
        s_bpdu_length = '0; s_flag_byte = '0; s_priority_word = '0; s_cost_word = '0;
        m_ready = 0; hold_cycles = 0; cycles = 0; mismatches = 0; items_sent = 0;
        results_seen = 0; full_seen = 0; s_idle_pct = 23; r_idle_pct = 52;
        t_now = 64'd1000;
        max_age = stp_pkg::MAX_AGE_RESET;
        fwd_delay = stp_pkg::FWD_DELAY_RESET;
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        none = '{'0, stp_pkg::ST_DISC, '0, '0, '0, stp_pkg::STATUS_OK, 1'b0};

        // directed table, default timers
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 0, 100, 100, 60, 1, 1, 1), 1, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 0, 0, 0, 0, 0, 0), 1, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 32'hFFFF_FFFF, 0, 100, 0, 8'hFF, 16'hFFFF,
                            32'hFFFF_FFFF),
                         1, 1, '{32'hFFFF_FFFF, stp_pkg::ST_LEARN, stp_pkg::DEF_PRIO,
                                 stp_pkg::DEF_COST, 64'd100, stp_pkg::STATUS_OK, 1'b1}});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 5, 200, 200, 255, 8'hFF, 16'hFFFF,
                            32'hFFFF_FFFF),
                         1, 1, '{32'd5, stp_pkg::ST_LEARN, 16'hFFFF, 32'hFFFF_FFFF, 64'd200,
                                 stp_pkg::STATUS_OK, 1'b1}});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 6, 300, 300, 21, 1, 1, 1), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 7, 400, 400, 22, 0, 16'h1234, 5), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 8, 500, 500, 23, 0, 16'h1234, 5), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 9, 600, 600, 24, 0, 16'h1234, 77), 0, 0,
                         none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 10, 700, 700, 33, 0, 16'h0, 77), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 11, 800, 800, 34, 0, 16'h8000, 32'hDEAD_BEEF),
                         0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 12, 0, 0, 40, 0, 1, 1), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 1000 + FWD_DEF, 0, 0, 0, 0, 0), 0, 0,
                         none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 13, 2000 + FWD_DEF, 2000 + FWD_DEF, 22, 1, 0,
                            0), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 50, 0, 0, 0, 0, 0), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 60, 0, 0, 0, 0, 0), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0),
                         0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_BPDU, 5, 64'hFFFF_FFFF_FFFF_FFF0, 0, 30, 8'hFE, 1,
                            1), 0, 0, none});
        rows.push_back('{mk(stp_pkg::CMD_TIMER, 0, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 0, 0),
                         0, 0, none});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) begin
            r = rows[k];
            offer_item(r.item);
            track_ports(r.item);
            if (r.typed) begin
                if (r.has_res) begin
                    if (step_wr.size() > 0) step_wr[step_wr.size() - 1] = r.final_wr;
                end else begin
                    step_wr.delete();
                end
            end
            foreach (step_wr[i]) pending_wr.push_back(step_wr[i]);
        end
        drain();

        write_timers(36'd3000, 36'd1500);
        random_phase(100);

        s_idle_pct = 52; r_idle_pct = 23;
        write_timers('0, '0);
        random_phase(40);
        write_timers({stp_pkg::CFG_W{1'b1}}, {stp_pkg::CFG_W{1'b1}});
        random_phase(40);

        s_idle_pct = 0; r_idle_pct = 0;
        write_timers(36'd5000, 36'd2000);
        hold_cycles = 400;
        random_phase(110);

        $display("%0d items sent, %0d entry writes checked (%0d table-full)",
                 items_sent, results_seen, full_seen);
        $display("timers run at reset values, 3000/1500, zero, all ones and 5000/2000");
        if (mismatches == 0) begin
            $display("[stp_port_state_tracker] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[stp_port_state_tracker] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/stp_pkg.sv
src/stp_slot_table.sv
src/stp_port_state_tracker.sv
bench/tb_stp_port_state_tracker.sv
